### sv/opw_pkg.sv
// Shared constants, types and state codes of the oil-paint window filter.
package opw_pkg;

    // Frame store and window geometry
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int MAX_RADIUS = 16;
    localparam int BIN_COUNT  = 256;

    localparam int FRAME_AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int BIN_AW   = $clog2(BIN_COUNT);
    localparam int CNT_W    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
    localparam int SUM_W    = CNT_W + 8;
    localparam int DIV_CW   = $clog2(SUM_W + 1);

    // Configuration register indexes
    localparam logic [2:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_WINDOW_RADIUS = 3'd2;
    localparam logic [2:0] REG_SMOOTHNESS    = 3'd3;
    localparam logic [2:0] REG_COLOR_MODE    = 3'd4;

    // Input actions
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef struct packed {
        logic       action;
        logic [8:0] col;
        logic [8:0] row;
        logic [7:0] in_luma;
        logic [7:0] in_cb;
        logic [7:0] in_cr;
    } opw_in_t;

    typedef struct packed {
        logic [7:0] out_luma;
        logic [7:0] out_cb;
        logic [7:0] out_cr;
    } opw_out_t;

    // One bin accumulator entry
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] sum_luma;
        logic [SUM_W-1:0] sum_cb;
        logic [SUM_W-1:0] sum_cr;
    } opw_bin_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CENTER,
        ST_WALK,
        ST_DRAIN,
        ST_SCAN,
        ST_SCAN_END,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } opw_state_t;

    typedef enum logic [1:0] {
        SEL_LUMA,
        SEL_CB,
        SEL_CR
    } opw_sel_t;

endpackage

### sv/opw_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the three bin means.
module opw_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [opw_pkg::SUM_W-1:0]  dividend,
    input  logic [opw_pkg::CNT_W-1:0]  divisor,
    output logic                       done,
    output logic [opw_pkg::SUM_W-1:0]  quotient
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [opw_pkg::DIV_CW-1:0]   cnt_reg;
    logic [opw_pkg::CNT_W-1:0]    rem_reg;
    logic [opw_pkg::CNT_W-1:0]    rem_next;
    logic [opw_pkg::SUM_W-1:0]    quo_reg;
    logic [opw_pkg::CNT_W-1:0]    dvs_reg;
    logic [opw_pkg::CNT_W:0]      shifted;
    logic                         qbit;

    // Shift in the next dividend bit and trial-subtract
    always_comb
    begin
        shifted = {rem_reg, quo_reg[opw_pkg::SUM_W-1]};
        qbit    = (shifted >= {1'b0, dvs_reg});
        if (qbit)
        begin
            rem_next = opw_pkg::CNT_W'(shifted - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = shifted[opw_pkg::CNT_W-1:0];
        end
    end

    // Control: count steps, pulse done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == opw_pkg::DIV_CW'(opw_pkg::SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[opw_pkg::SUM_W-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### sv/oil_paint_window_filter.sv
// Oil-paint window filter: frame store, bin histogram sequencer and APB registers.
// Load word: written to the frame store on acceptance, no result.
// Compute word: center read, window walk, drain, bin scan, then one division per mean
//   (one mean in luma mode, three in color mode); the window walk reads one
//   frame sample per cycle and the bin scan reads one bin accumulator per cycle.
// One word at a time; in_ready is low while a compute word is in progress and
//   while a finished word waits for the output register to free up.
// Reset is asynchronous active low: registers take their reset values, bin valid
// bits clear at each compute word; the frame store holds no reset value.
module oil_paint_window_filter
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  opw_pkg::opw_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output opw_pkg::opw_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Configuration registers
    logic [9:0] width_reg;
    logic [9:0] height_reg;
    logic [4:0] radius_reg;
    logic [7:0] smooth_reg;
    logic       color_reg;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 10'd512;
            height_reg <= 10'd512;
            radius_reg <= 5'd4;
            smooth_reg <= 8'd4;
            color_reg  <= 1'b0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                opw_pkg::REG_FRAME_WIDTH:   width_reg  <= pwdata[9:0];
                opw_pkg::REG_FRAME_HEIGHT:  height_reg <= pwdata[9:0];
                opw_pkg::REG_WINDOW_RADIUS: radius_reg <= pwdata[4:0];
                opw_pkg::REG_SMOOTHNESS:    smooth_reg <= pwdata[7:0];
                opw_pkg::REG_COLOR_MODE:    color_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            opw_pkg::REG_FRAME_WIDTH:   prdata = {22'd0, width_reg};
            opw_pkg::REG_FRAME_HEIGHT:  prdata = {22'd0, height_reg};
            opw_pkg::REG_WINDOW_RADIUS: prdata = {27'd0, radius_reg};
            opw_pkg::REG_SMOOTHNESS:    prdata = {24'd0, smooth_reg};
            opw_pkg::REG_COLOR_MODE:    prdata = {31'd0, color_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // Saturated settings
    logic [9:0] w_eff;
    logic [9:0] h_eff;
    logic [4:0] r_eff;
    logic [8:0] bins_eff;

    always_comb
    begin
        if (width_reg == 10'd0)
            w_eff = 10'd1;
        else if (width_reg > 10'(opw_pkg::MAX_WIDTH))
            w_eff = 10'(opw_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == 10'd0)
            h_eff = 10'd1;
        else if (height_reg > 10'(opw_pkg::MAX_HEIGHT))
            h_eff = 10'(opw_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
        if (radius_reg > 5'(opw_pkg::MAX_RADIUS))
            r_eff = 5'(opw_pkg::MAX_RADIUS);
        else
            r_eff = radius_reg;
        if ({1'b0, smooth_reg} + 9'd1 > 9'(opw_pkg::BIN_COUNT))
            bins_eff = 9'(opw_pkg::BIN_COUNT);
        else
            bins_eff = {1'b0, smooth_reg} + 9'd1;
    end

    // Request decode and window bounds
    logic [9:0] col10;
    logic [9:0] row10;
    logic       req_inside;
    logic [9:0] x0_calc;
    logic [9:0] x1_calc;
    logic [9:0] y0_calc;
    logic [9:0] y1_calc;
    logic       accept;
    logic       load_we;

    assign col10      = {1'b0, in_data.col};
    assign row10      = {1'b0, in_data.row};
    assign req_inside = (col10 < w_eff) && (row10 < h_eff);
    assign accept     = in_valid && in_ready;
    assign load_we    = accept && (in_data.action == opw_pkg::ACT_LOAD)
                        && (col10 < 10'(opw_pkg::MAX_WIDTH))
                        && (row10 < 10'(opw_pkg::MAX_HEIGHT));

    always_comb
    begin
        x0_calc = (col10 > {5'd0, r_eff}) ? col10 - {5'd0, r_eff} : 10'd0;
        x1_calc = (col10 + {5'd0, r_eff} < w_eff) ? col10 + {5'd0, r_eff} : w_eff - 10'd1;
        y0_calc = (row10 > {5'd0, r_eff}) ? row10 - {5'd0, r_eff} : 10'd0;
        y1_calc = (row10 + {5'd0, r_eff} < h_eff) ? row10 + {5'd0, r_eff} : h_eff - 10'd1;
    end

    // Sequencer state
    opw_pkg::opw_state_t state_reg;
    opw_pkg::opw_state_t state_next;

    logic [9:0]                  x_reg;
    logic [9:0]                  y_reg;
    logic [9:0]                  x0_reg;
    logic [9:0]                  x1_reg;
    logic [9:0]                  y1_reg;
    logic [opw_pkg::FRAME_AW-1:0] cen_addr_reg;
    logic                        s1_v_reg;
    logic                        s2_v_reg;
    logic [opw_pkg::BIN_AW-1:0]  scan_idx_reg;
    logic                        div_done;
    opw_pkg::opw_sel_t           sel_reg;
    logic                        out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            opw_pkg::ST_IDLE:
            begin
                if (accept && (in_data.action == opw_pkg::ACT_COMPUTE) && req_inside)
                    state_next = opw_pkg::ST_CENTER;
            end
            opw_pkg::ST_CENTER:
                state_next = opw_pkg::ST_WALK;
            opw_pkg::ST_WALK:
            begin
                if (x_reg == x1_reg && y_reg == y1_reg)
                    state_next = opw_pkg::ST_DRAIN;
            end
            opw_pkg::ST_DRAIN:
            begin
                if (!s1_v_reg && !s2_v_reg)
                    state_next = opw_pkg::ST_SCAN;
            end
            opw_pkg::ST_SCAN:
            begin
                if ({1'b0, scan_idx_reg} == bins_eff - 9'd1)
                    state_next = opw_pkg::ST_SCAN_END;
            end
            opw_pkg::ST_SCAN_END:
                state_next = opw_pkg::ST_DIV_GO;
            opw_pkg::ST_DIV_GO:
                state_next = opw_pkg::ST_DIV_WAIT;
            opw_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (!color_reg || sel_reg == opw_pkg::SEL_CR)
                        state_next = opw_pkg::ST_DONE;
                    else
                        state_next = opw_pkg::ST_DIV_GO;
                end
            end
            opw_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = opw_pkg::ST_IDLE;
            end
            default:
                state_next = opw_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    logic                         fr_walk;
    logic                         scan_rd;
    logic                         div_start;
    logic                         out_load;
    logic [opw_pkg::FRAME_AW-1:0] fr_raddr;
    logic [opw_pkg::FRAME_AW-1:0] walk_addr;

    assign walk_addr = opw_pkg::FRAME_AW'(y_reg) * opw_pkg::FRAME_AW'(opw_pkg::MAX_WIDTH)
                       + opw_pkg::FRAME_AW'(x_reg);

    always_comb
    begin
        in_ready  = 1'b0;
        fr_walk   = 1'b0;
        scan_rd   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        fr_raddr  = cen_addr_reg;
        case (state_reg)
            opw_pkg::ST_IDLE:   in_ready = 1'b1;
            opw_pkg::ST_CENTER: fr_raddr = cen_addr_reg;
            opw_pkg::ST_WALK:
            begin
                fr_walk  = 1'b1;
                fr_raddr = walk_addr;
            end
            opw_pkg::ST_SCAN:   scan_rd = 1'b1;
            opw_pkg::ST_DIV_GO: div_start = 1'b1;
            opw_pkg::ST_DONE:   out_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    // Walk counters and request latches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= opw_pkg::ST_IDLE;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            scan_idx_reg  <= '0;
            sel_reg       <= opw_pkg::SEL_LUMA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1_v_reg  <= fr_walk;
            s2_v_reg  <= s1_v_reg;
            if (state_reg == opw_pkg::ST_CENTER)
                scan_idx_reg <= '0;
            else if (scan_rd)
                scan_idx_reg <= scan_idx_reg + 1'b1;
            if (state_reg == opw_pkg::ST_SCAN_END)
                sel_reg <= opw_pkg::SEL_LUMA;
            else if (state_reg == opw_pkg::ST_DIV_WAIT && div_done)
            begin
                case (sel_reg)
                    opw_pkg::SEL_LUMA: sel_reg <= opw_pkg::SEL_CB;
                    default:           sel_reg <= opw_pkg::SEL_CR;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x0_reg       <= x0_calc;
            x1_reg       <= x1_calc;
            y1_reg       <= y1_calc;
            x_reg        <= x0_calc;
            y_reg        <= y0_calc;
            cen_addr_reg <= opw_pkg::FRAME_AW'(in_data.row)
                            * opw_pkg::FRAME_AW'(opw_pkg::MAX_WIDTH)
                            + opw_pkg::FRAME_AW'(in_data.col);
        end
        else if (fr_walk)
        begin
            if (x_reg == x1_reg)
            begin
                x_reg <= x0_reg;
                y_reg <= y_reg + 10'd1;
            end
            else
            begin
                x_reg <= x_reg + 10'd1;
            end
        end
    end

    // Frame store: one write, one registered read
    logic [23:0] frame_mem [opw_pkg::MAX_WIDTH * opw_pkg::MAX_HEIGHT];
    logic [23:0] fr_q_reg;
    logic [opw_pkg::FRAME_AW-1:0] fr_waddr;

    assign fr_waddr = opw_pkg::FRAME_AW'(in_data.row) * opw_pkg::FRAME_AW'(opw_pkg::MAX_WIDTH)
                      + opw_pkg::FRAME_AW'(in_data.col);

    always_ff @(posedge clk)
    begin
        if (load_we)
            frame_mem[fr_waddr] <= {in_data.in_luma, in_data.in_cb, in_data.in_cr};
        fr_q_reg <= frame_mem[fr_raddr];
    end

    // Capture the center chroma in the cycle after its read
    logic       cap_reg;
    logic [7:0] cen_cb_reg;
    logic [7:0] cen_cr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= 1'b0;
        else
            cap_reg <= (state_reg == opw_pkg::ST_CENTER);
    end

    always_ff @(posedge clk)
    begin
        if (cap_reg)
        begin
            cen_cb_reg <= fr_q_reg[15:8];
            cen_cr_reg <= fr_q_reg[7:0];
        end
    end

    // Bin index: round(Y*smoothness/255) via shift-add reciprocal
    logic [15:0]                bin_prod;
    logic [16:0]                bin_rec;
    logic [8:0]                 bin_raw;
    logic [opw_pkg::BIN_AW-1:0] s1_bin;

    always_comb
    begin
        bin_prod = 16'(fr_q_reg[23:16] * smooth_reg) + 16'd127;
        bin_rec  = {1'b0, bin_prod} + {9'd0, bin_prod[15:8]} + 17'd1;
        bin_raw  = bin_rec[16:8];
        if (bin_raw > 9'(opw_pkg::BIN_COUNT - 1))
            s1_bin = opw_pkg::BIN_AW'(opw_pkg::BIN_COUNT - 1);
        else
            s1_bin = bin_raw[opw_pkg::BIN_AW-1:0];
    end

    // Bin accumulator memory with per-entry valid bits
    opw_pkg::opw_bin_t          bin_mem [opw_pkg::BIN_COUNT];
    opw_pkg::opw_bin_t          bin_q_reg;
    logic [opw_pkg::BIN_COUNT-1:0] bv_reg;
    logic                       rd_bv_reg;
    logic [opw_pkg::BIN_AW-1:0] bin_raddr;
    logic [opw_pkg::BIN_AW-1:0] s2_bin_reg;
    logic [23:0]                s2_pix_reg;
    logic                       lw_v_reg;
    logic [opw_pkg::BIN_AW-1:0] lw_idx_reg;
    opw_pkg::opw_bin_t          lw_data_reg;
    opw_pkg::opw_bin_t          acc_base;
    opw_pkg::opw_bin_t          acc_new;

    assign bin_raddr = scan_rd ? scan_idx_reg : s1_bin;

    // Accumulate, forwarding the write of the previous cycle
    always_comb
    begin
        if (lw_v_reg && lw_idx_reg == s2_bin_reg)
            acc_base = lw_data_reg;
        else if (rd_bv_reg)
            acc_base = bin_q_reg;
        else
            acc_base = '0;
        acc_new.cnt      = acc_base.cnt + 1'b1;
        acc_new.sum_luma = acc_base.sum_luma + opw_pkg::SUM_W'(s2_pix_reg[23:16]);
        acc_new.sum_cb   = acc_base.sum_cb + opw_pkg::SUM_W'(s2_pix_reg[15:8]);
        acc_new.sum_cr   = acc_base.sum_cr + opw_pkg::SUM_W'(s2_pix_reg[7:0]);
    end

    always_ff @(posedge clk)
    begin
        if (s2_v_reg)
            bin_mem[s2_bin_reg] <= acc_new;
        bin_q_reg   <= bin_mem[bin_raddr];
        s2_bin_reg  <= s1_bin;
        s2_pix_reg  <= fr_q_reg;
        lw_idx_reg  <= s2_bin_reg;
        lw_data_reg <= acc_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg    <= '0;
            rd_bv_reg <= 1'b0;
            lw_v_reg  <= 1'b0;
        end
        else
        begin
            rd_bv_reg <= bv_reg[bin_raddr];
            lw_v_reg  <= s2_v_reg;
            if (state_reg == opw_pkg::ST_CENTER)
                bv_reg <= '0;
            else if (s2_v_reg)
                bv_reg[s2_bin_reg] <= 1'b1;
        end
    end

    // Peak search, lowest bin wins ties
    logic                       sc_v_reg;
    logic [opw_pkg::BIN_AW-1:0] sc_idx_reg;
    opw_pkg::opw_bin_t          sc_entry;
    opw_pkg::opw_bin_t          peak_reg;

    assign sc_entry = rd_bv_reg ? bin_q_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_v_reg <= 1'b0;
        else
            sc_v_reg <= scan_rd;
    end

    always_ff @(posedge clk)
    begin
        sc_idx_reg <= scan_idx_reg;
        if (sc_v_reg && (sc_idx_reg == '0 || sc_entry.cnt > peak_reg.cnt))
            peak_reg <= sc_entry;
    end

    // Mean of the winning bin through the shared divider
    logic [opw_pkg::SUM_W-1:0] div_dividend;
    logic [opw_pkg::SUM_W-1:0] div_quotient;
    logic [7:0]                res_luma_reg;
    logic [7:0]                res_cb_reg;
    logic [7:0]                res_cr_reg;

    always_comb
    begin
        case (sel_reg)
            opw_pkg::SEL_LUMA: div_dividend = peak_reg.sum_luma;
            opw_pkg::SEL_CB:   div_dividend = peak_reg.sum_cb;
            opw_pkg::SEL_CR:   div_dividend = peak_reg.sum_cr;
            default:           div_dividend = peak_reg.sum_luma;
        endcase
    end

    opw_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (peak_reg.cnt),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == opw_pkg::ST_DIV_WAIT && div_done)
        begin
            case (sel_reg)
                opw_pkg::SEL_LUMA: res_luma_reg <= div_quotient[7:0];
                opw_pkg::SEL_CB:   res_cb_reg   <= div_quotient[7:0];
                default:           res_cr_reg   <= div_quotient[7:0];
            endcase
        end
    end

    // Output register: hold the word until taken
    opw_pkg::opw_out_t out_data_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.out_luma <= res_luma_reg;
            out_data_reg.out_cb   <= color_reg ? res_cb_reg : cen_cb_reg;
            out_data_reg.out_cr   <= color_reg ? res_cr_reg : cen_cr_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### tb/oil_paint_window_filter_tb.sv
// Self-checking testbench of the oil-paint window filter: directed table, then random frames.
module oil_paint_window_filter_tb;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    opw_pkg::opw_in_t  in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    opw_pkg::opw_out_t out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Shadow of the block state
    logic [7:0] pix_luma [int];
    logic [7:0] pix_cb [int];
    logic [7:0] pix_cr [int];
    int unsigned cfg_width, cfg_height, cfg_radius, cfg_smooth, cfg_color;

    opw_pkg::opw_out_t pending_pixels [$];
    int         fail_count = 0;
    int         cycle_count = 0;
    bit         long_hold = 1'b0;

    oil_paint_window_filter uut
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // Limit the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 4000000)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Oil-paint value of one pixel from the shadow frame
    function automatic opw_pkg::opw_out_t paint_pixel(int unsigned c, int unsigned r);
        int unsigned w, h, rad, nbins, x0, x1, y0, y1, b, peak, a;
        int unsigned cnt [256];
        int unsigned sl [256];
        int unsigned sb [256];
        int unsigned sr [256];
        opw_pkg::opw_out_t res;
        w = (cfg_width < 1) ? 1
            : (cfg_width > opw_pkg::MAX_WIDTH ? opw_pkg::MAX_WIDTH : cfg_width);
        h = (cfg_height < 1) ? 1
            : (cfg_height > opw_pkg::MAX_HEIGHT ? opw_pkg::MAX_HEIGHT : cfg_height);
        rad = (cfg_radius > opw_pkg::MAX_RADIUS) ? opw_pkg::MAX_RADIUS : cfg_radius;
        nbins = (cfg_smooth + 1 > opw_pkg::BIN_COUNT) ? opw_pkg::BIN_COUNT : cfg_smooth + 1;
        for (int i = 0; i < 256; i++)
        begin
            cnt[i] = 0; sl[i] = 0; sb[i] = 0; sr[i] = 0;
        end
        x0 = (c > rad) ? c - rad : 0;
        x1 = (c + rad < w) ? c + rad : w - 1;
        y0 = (r > rad) ? r - rad : 0;
        y1 = (r + rad < h) ? r + rad : h - 1;
        for (int unsigned y = y0; y <= y1; y++)
            for (int unsigned x = x0; x <= x1; x++)
            begin
                a = y * opw_pkg::MAX_WIDTH + x;
                b = (pix_luma[a] * cfg_smooth + 127) / 255;
                if (b > opw_pkg::BIN_COUNT - 1) b = opw_pkg::BIN_COUNT - 1;
                cnt[b]++; sl[b] += pix_luma[a]; sb[b] += pix_cb[a]; sr[b] += pix_cr[a];
            end
        peak = 0;
        for (int unsigned i = 1; i < nbins; i++)
            if (cnt[i] > cnt[peak]) peak = i;
        a = r * opw_pkg::MAX_WIDTH + c;
        res.out_luma = 8'(sl[peak] / cnt[peak]);
        res.out_cb = cfg_color ? 8'(sb[peak] / cnt[peak]) : pix_cb[a];
        res.out_cr = cfg_color ? 8'(sr[peak] / cnt[peak]) : pix_cr[a];
        return res;
    endfunction

    // Update the shadow for one accepted word
    task automatic track_word(opw_pkg::opw_in_t wd);
        int a;
        a = wd.row * opw_pkg::MAX_WIDTH + wd.col;
        if (wd.action == opw_pkg::ACT_LOAD)
        begin
            pix_luma[a] = wd.in_luma; pix_cb[a] = wd.in_cb; pix_cr[a] = wd.in_cr;
        end
        else if (wd.col < cfg_width && wd.row < cfg_height)
            pending_pixels.push_back(paint_pixel(wd.col, wd.row));
    endtask

    // Offer one word and hold it until accepted
    task automatic send_word(opw_pkg::opw_in_t wd);
        @(negedge clk);
        in_data <= wd;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        track_word(wd);
        if ($urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Write one register between phases
    task automatic write_reg(logic [2:0] idx, int unsigned val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            opw_pkg::REG_FRAME_WIDTH:   cfg_width = val;
            opw_pkg::REG_FRAME_HEIGHT:  cfg_height = val;
            opw_pkg::REG_WINDOW_RADIUS: cfg_radius = val;
            opw_pkg::REG_SMOOTHNESS:    cfg_smooth = val;
            default:                    cfg_color = val;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_config(int unsigned w, int unsigned h, int unsigned rad,
                              int unsigned sm, int unsigned cm);
        drop_valid();
        wait_idle();
        write_reg(opw_pkg::REG_FRAME_WIDTH, w);
        write_reg(opw_pkg::REG_FRAME_HEIGHT, h);
        write_reg(opw_pkg::REG_WINDOW_RADIUS, rad);
        write_reg(opw_pkg::REG_SMOOTHNESS, sm);
        write_reg(opw_pkg::REG_COLOR_MODE, cm);
    endtask

    function automatic opw_pkg::opw_in_t make_word(logic act, int c, int r, int y, int cb,
                                                   int cr);
        opw_pkg::opw_in_t wd;
        wd.action = act; wd.col = 9'(c); wd.row = 9'(r);
        wd.in_luma = 8'(y); wd.in_cb = 8'(cb); wd.in_cr = 8'(cr);
        return wd;
    endfunction

    // Load a whole frame of random pixels, then compute at random spots
    task automatic random_frame(int unsigned w, int unsigned h, int n_compute);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                send_word(make_word(opw_pkg::ACT_LOAD, c, r,
                                    ($urandom_range(0, 1) ? $urandom_range(0, 255)
                                    : $urandom_range(100, 110)), $urandom_range(0, 255),
                                    $urandom_range(0, 255)));
        for (int k = 0; k < n_compute; k++)
        begin
            // Occasionally aim outside the frame
            if ($urandom_range(0, 9) == 0)
                send_word(make_word(opw_pkg::ACT_COMPUTE, $urandom_range(w, 511),
                                    $urandom_range(0, 511), $urandom, $urandom, $urandom));
            else
                send_word(make_word(opw_pkg::ACT_COMPUTE, $urandom_range(0, w - 1),
                                    $urandom_range(0, h - 1), $urandom, $urandom, $urandom));
        end
    endtask

    // Receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (long_hold)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 3) != 0) || (cycle_count[9:8] == 2'b00);
    end

    initial
    begin
        @(negedge clk);
        long_hold = 1'b1;
        repeat (30000) @(negedge clk);
        long_hold = 1'b0;
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("unexpected result word %h", out_data);
                fail_count++;
            end
            else
            begin
                opw_pkg::opw_out_t exp_px;
                exp_px = pending_pixels.pop_front();
                if (out_data.out_luma !== exp_px.out_luma)
                begin
                    $error("out_luma expected %0d got %0d", exp_px.out_luma, out_data.out_luma);
                    fail_count++;
                end
                if (out_data.out_cb !== exp_px.out_cb)
                begin
                    $error("out_cb expected %0d got %0d", exp_px.out_cb, out_data.out_cb);
                    fail_count++;
                end
                if (out_data.out_cr !== exp_px.out_cr)
                begin
                    $error("out_cr expected %0d got %0d", exp_px.out_cr, out_data.out_cr);
                    fail_count++;
                end
            end
        end
    end

    typedef struct {
        opw_pkg::opw_in_t  wd;
        bit                has_exp;
        opw_pkg::opw_out_t exp_px;
    } stim_row_t;

    stim_row_t  stim_table [$];

    // Walk the table, comparing typed expectations with the predictor
    task automatic run_table();
        foreach (stim_table[i])
        begin
            send_word(stim_table[i].wd);
            if (stim_table[i].has_exp && pending_pixels.size() != 0
                && pending_pixels[$] != stim_table[i].exp_px)
            begin
                $error("table row %0d: predictor disagrees", i);
                fail_count++;
            end
        end
        stim_table.delete();
    endtask

    initial
    begin
        cfg_width = 512; cfg_height = 512; cfg_radius = 4; cfg_smooth = 4; cfg_color = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: corner block of the store, a lone pixel frame, small frame pixels
        for (int r = 507; r < 512; r++)
            for (int c = 507; c < 512; c++)
                stim_table.push_back('{make_word(opw_pkg::ACT_LOAD, c, r, 0, 255, 0), 0, '0});
        stim_table.push_back('{make_word(opw_pkg::ACT_LOAD, 0, 0, 255, 0, 255), 0, '0});
        stim_table.push_back('{make_word(opw_pkg::ACT_LOAD, 1, 0, 128, 17, 200), 0, '0});
        stim_table.push_back('{make_word(opw_pkg::ACT_LOAD, 0, 1, 3, 9, 1), 0, '0});
        stim_table.push_back('{make_word(opw_pkg::ACT_LOAD, 1, 1, 255, 40, 60), 0, '0});
        stim_table.push_back('{make_word(opw_pkg::ACT_COMPUTE, 511, 511, 0, 0, 0), 1,
                               '{8'd0, 8'd255, 8'd0}});
        run_table();

        // Single pixel frame: window holds only the pixel itself
        set_config(1, 1, 16, 255, 1);
        stim_table.push_back('{make_word(opw_pkg::ACT_COMPUTE, 0, 0, 0, 0, 0), 1,
                               '{8'd255, 8'd0, 8'd255}});
        stim_table.push_back('{make_word(opw_pkg::ACT_COMPUTE, 1, 0, 0, 0, 0), 0, '0});
        stim_table.push_back('{make_word(opw_pkg::ACT_COMPUTE, 0, 1, 0, 0, 0), 0, '0});
        run_table();

        // Two by two frame, smoothness zero (one bin) and radius zero and one
        set_config(2, 2, 0, 0, 1);
        for (int k = 0; k < 4; k++)
            send_word(make_word(opw_pkg::ACT_COMPUTE, k % 2, k / 2, 0, 0, 0));
        set_config(2, 2, 1, 0, 0);
        for (int k = 0; k < 4; k++)
            send_word(make_word(opw_pkg::ACT_COMPUTE, k % 2, k / 2, 0, 0, 0));

        // Random phases, several settings including the extremes
        set_config(6, 5, 2, 1, 0);
        random_frame(6, 5, 40);
        set_config(9, 7, 3, 255, 1);
        random_frame(9, 7, 50);
        set_config(8, 8, 16, 4, 1);
        random_frame(8, 8, 30);
        set_config(12, 4, 5, $urandom_range(2, 30), 0);
        random_frame(12, 4, 40);
        // Full width row exercises the widest window
        set_config(512, 1, 16, 128, 1);
        for (int c = 0; c < 40; c++)
            send_word(make_word(opw_pkg::ACT_LOAD, c, 0, $urandom, $urandom, $urandom));
        for (int k = 0; k < 15; k++)
            send_word(make_word(opw_pkg::ACT_COMPUTE, $urandom_range(0, 39 - 16), 0, 0, 0, 0));
        send_word(make_word(opw_pkg::ACT_COMPUTE, 0, 1, 0, 0, 0));

        drop_valid();
        wait_idle();
        repeat (2000) @(posedge clk);
        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
